FILE: rtl/icaf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icaf_pkg
// Shared types, constants and the arctangent table of the attitude filter.
// ----------------------------------------------------------------------------
package icaf_pkg;

	localparam int ATAN_STEPS = 16;
	localparam int STEP_W     = $clog2(ATAN_STEPS);
	localparam int DIV_W      = 42;
	localparam int DIV_CNT_W  = $clog2(DIV_W);

	localparam logic signed [31:0] DEG90 = 32'sd5898240;

	localparam logic [31:0] ATAN_TABLE [32] = '{
		32'd2949120, 32'd1740967, 32'd919879, 32'd466945,
		32'd234379,  32'd117304,  32'd58666,  32'd29335,
		32'd14668,   32'd7334,    32'd3667,   32'd1833,
		32'd917,     32'd458,     32'd229,    32'd115,
		32'd57,      32'd29,      32'd14,     32'd7,
		32'd4,       32'd2,       32'd1,      32'd0,
		32'd0,       32'd0,       32'd0,      32'd0,
		32'd0,       32'd0,       32'd0,      32'd0
	};

	typedef enum logic [2:0] {
		CFG_BLEND_WEIGHT = 3'd0,
		CFG_TICK_PERIOD  = 3'd1,
		CFG_GYRO_SENS    = 3'd2,
		CFG_OFFSET_X     = 3'd3,
		CFG_OFFSET_Y     = 3'd4,
		CFG_OFFSET_Z     = 3'd5
	} cfg_idx_t;

	typedef enum logic [2:0] {
		S_IDLE, S_START, S_LANES, S_BLEND, S_OUT
	} top_state_t;

	typedef enum logic [2:0] {
		G_IDLE, G_MUL1, G_MUL2, G_DIV, G_SAT, G_DONE
	} gyro_state_t;

	typedef enum logic [1:0] {
		T_IDLE, T_RUN, T_DONE
	} tilt_state_t;

	typedef enum logic [1:0] {
		B_IDLE, B_SUM, B_DONE
	} blend_state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} lane_stat_t;

endpackage

FILE: rtl/icaf_gyro_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icaf_gyro_lane
// One gyro axis: bias removal, rate times elapsed time, serial division by
// the sensitivity, and saturating accumulation onto the stored angle.
// ----------------------------------------------------------------------------
module icaf_gyro_lane (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic signed [15:0]  raw,
	input  logic signed [15:0]  offset,
	input  logic        [15:0]  ticks,
	input  logic        [23:0]  tick_period,
	input  logic        [7:0]   sens,
	input  logic signed [31:0]  store,
	output logic signed [31:0]  angle,
	output icaf_pkg::lane_stat_t stat
);

	icaf_pkg::gyro_state_t state_q, state_d;

	logic signed [16:0]             diff;
	logic        [16:0]             mag_q;
	logic                           neg_q;
	logic        [32:0]             p1_q;
	logic        [56:0]             p2;
	logic        [57:0]             rnd;
	logic        [7:0]              s_eff;
	logic        [icaf_pkg::DIV_W-1:0] num_q;
	logic        [7:0]              rem_q;
	logic        [8:0]              trial;
	logic                           qbit;
	logic        [icaf_pkg::DIV_CNT_W-1:0] cnt_q;
	logic signed [43:0]             qs;
	logic signed [43:0]             sum;
	logic signed [31:0]             angle_q;

	assign diff  = 17'({raw[15], raw}) - 17'({offset[15], offset});
	assign s_eff = (sens == 8'd0) ? 8'd1 : sens;
	assign p2    = 57'(p1_q) * 57'(tick_period);
	assign rnd   = 58'(p2) + ({50'd0, s_eff} << 15);
	assign trial = {rem_q, num_q[icaf_pkg::DIV_W-1]};
	assign qbit  = (trial >= {1'b0, s_eff});
	assign qs    = neg_q ? -$signed({2'b00, num_q}) : $signed({2'b00, num_q});
	assign sum   = $signed({{12{store[31]}}, store}) + qs;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= icaf_pkg::G_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			icaf_pkg::G_IDLE: if (start) state_d = icaf_pkg::G_MUL1;
			icaf_pkg::G_MUL1: state_d = icaf_pkg::G_MUL2;
			icaf_pkg::G_MUL2: state_d = icaf_pkg::G_DIV;
			icaf_pkg::G_DIV: begin
				if (cnt_q == icaf_pkg::DIV_CNT_W'(icaf_pkg::DIV_W - 1))
					state_d = icaf_pkg::G_SAT;
			end
			icaf_pkg::G_SAT:  state_d = icaf_pkg::G_DONE;
			icaf_pkg::G_DONE: if (start) state_d = icaf_pkg::G_MUL1;
			default:          state_d = icaf_pkg::G_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mag_q <= diff[16] ? 17'(-diff) : 17'(diff);
			neg_q <= diff[16];
		end
		if (state_q == icaf_pkg::G_MUL1)
			p1_q <= 33'(mag_q) * 33'(ticks);
		if (state_q == icaf_pkg::G_MUL2) begin
			num_q <= rnd[57:16];
			rem_q <= 8'd0;
			cnt_q <= '0;
		end
		if (state_q == icaf_pkg::G_DIV) begin
			num_q <= {num_q[icaf_pkg::DIV_W-2:0], qbit};
			rem_q <= qbit ? 8'(trial - {1'b0, s_eff}) : trial[7:0];
			cnt_q <= cnt_q + 1'b1;
		end
		if (state_q == icaf_pkg::G_SAT) begin
			if (sum > 44'sd2147483647)
				angle_q <= 32'sh7fffffff;
			else if (sum < -44'sd2147483648)
				angle_q <= 32'sh80000000;
			else
				angle_q <= sum[31:0];
		end
	end

	assign angle     = angle_q;
	assign stat.done = (state_q == icaf_pkg::G_DONE);
	assign stat.busy = (state_q != icaf_pkg::G_IDLE) && (state_q != icaf_pkg::G_DONE);

endmodule

FILE: rtl/icaf_tilt_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icaf_tilt_lane
// Accelerometer tilt angle atan(num/den) in degrees by iterative vectoring
// rotation, one micro-rotation per cycle.
// ----------------------------------------------------------------------------
module icaf_tilt_lane (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic signed [15:0]  num,
	input  logic signed [15:0]  den,
	output logic signed [31:0]  angle,
	output icaf_pkg::lane_stat_t stat
);

	icaf_pkg::tilt_state_t state_q, state_d;

	logic                           trivial;
	logic signed [16:0]             n17;
	logic        [16:0]             dabs;
	logic signed [33:0]             x_q, y_q, xs, ys;
	logic signed [31:0]             z_q;
	logic signed [31:0]             tab;
	logic        [icaf_pkg::STEP_W-1:0] i_q;

	assign trivial = (num == 16'sd0) || (den == 16'sd0);
	assign n17  = den[15] ? 17'(-$signed({num[15], num})) : $signed({num[15], num});
	assign dabs = den[15] ? 17'(-$signed({den[15], den})) : 17'({den[15], den});
	assign xs   = x_q >>> i_q;
	assign ys   = y_q >>> i_q;
	assign tab  = $signed(icaf_pkg::ATAN_TABLE[i_q]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= icaf_pkg::T_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			icaf_pkg::T_IDLE, icaf_pkg::T_DONE: begin
				if (start) state_d = trivial ? icaf_pkg::T_DONE : icaf_pkg::T_RUN;
			end
			icaf_pkg::T_RUN: begin
				if (i_q == icaf_pkg::STEP_W'(icaf_pkg::ATAN_STEPS - 1))
					state_d = icaf_pkg::T_DONE;
			end
			default: state_d = icaf_pkg::T_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= $signed({3'b000, dabs, 14'd0});
			y_q <= $signed({{3{n17[16]}}, n17, 14'd0});
			i_q <= '0;
			if (num == 16'sd0)
				z_q <= 32'sd0;
			else if (den == 16'sd0)
				z_q <= num[15] ? -icaf_pkg::DEG90 : icaf_pkg::DEG90;
			else
				z_q <= 32'sd0;
		end else if (state_q == icaf_pkg::T_RUN) begin
			if (!y_q[33]) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + tab;
			end else begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - tab;
			end
			i_q <= i_q + 1'b1;
		end
	end

	assign angle     = z_q;
	assign stat.done = (state_q == icaf_pkg::T_DONE);
	assign stat.busy = (state_q == icaf_pkg::T_RUN);

endmodule

FILE: rtl/icaf_blend.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icaf_blend
// Merge stage: weighted mix of the gyro angle and the tilt angle, rounded.
// ----------------------------------------------------------------------------
module icaf_blend (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic        [16:0]  weight,
	input  logic signed [31:0]  gyro,
	input  logic signed [31:0]  tilt,
	output logic signed [31:0]  angle,
	output icaf_pkg::lane_stat_t stat
);

	icaf_pkg::blend_state_t state_q, state_d;

	logic        [16:0]  wc, wa;
	logic signed [49:0]  pg_s1, pa_s1;
	logic signed [50:0]  sum;
	logic signed [31:0]  angle_q;

	assign wc  = (weight > 17'd65536) ? 17'd65536 : weight;
	assign wa  = 17'd65536 - wc;
	assign sum = 51'(pg_s1) + 51'(pa_s1) + 51'sd32768;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= icaf_pkg::B_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			icaf_pkg::B_IDLE, icaf_pkg::B_DONE: if (start) state_d = icaf_pkg::B_SUM;
			icaf_pkg::B_SUM: state_d = icaf_pkg::B_DONE;
			default:         state_d = icaf_pkg::B_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (start) begin
			pg_s1 <= $signed({1'b0, wc}) * gyro;
			pa_s1 <= $signed({1'b0, wa}) * tilt;
		end
		if (state_q == icaf_pkg::B_SUM)
			angle_q <= sum[47:16];
	end

	assign angle     = angle_q;
	assign stat.done = (state_q == icaf_pkg::B_DONE);
	assign stat.busy = (state_q == icaf_pkg::B_SUM);

endmodule

FILE: rtl/imu_complementary_attitude_filter_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_complementary_attitude_filter_top
// Complementary roll/pitch/yaw filter on raw IMU words, Q16.16 degrees.
//
// Input channel (in_valid/in_ready) takes one raw sample word: three
// accelerometer axes, three gyro axes and the elapsed tick count. Output
// channel (out_valid/out_ready) gives one word of roll, pitch and yaw.
// Three gyro lanes and two tilt lanes run side by side; two blend units
// merge roll and pitch. The 42-step serial division in the gyro lanes sets
// the time from accept to out_valid; the 16-step tilt rotation finishes in
// its shadow. One sample is in flight at a time: a new sample is not
// accepted until the previous one has left the lanes and blend units.
// A finished word sits in the output register; the next sample can be
// accepted while it waits, and its result waits in the lanes until the
// receiver takes the previous word. Reset clears the stored angles to
// zero and loads the default settings. The user must write settings
// through cfg_we/cfg_index/cfg_data only while idle; this is not enforced.
// ----------------------------------------------------------------------------
module imu_complementary_attitude_filter_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic signed [15:0]  accel_x,
	input  logic signed [15:0]  accel_y,
	input  logic signed [15:0]  accel_z,
	input  logic signed [15:0]  rate_x,
	input  logic signed [15:0]  rate_y,
	input  logic signed [15:0]  rate_z,
	input  logic        [15:0]  elapsed_ticks,
	output logic                out_valid,
	input  logic                out_ready,
	output logic signed [31:0]  roll_angle,
	output logic signed [31:0]  pitch_angle,
	output logic signed [31:0]  yaw_angle,
	input  logic                cfg_we,
	input  logic        [2:0]   cfg_index,
	input  logic        [23:0]  cfg_data
);

	icaf_pkg::top_state_t state_q, state_d;

	logic        [16:0] blend_weight_q;
	logic        [23:0] tick_period_q;
	logic        [7:0]  gyro_sens_q;
	logic signed [15:0] off_x_q, off_y_q, off_z_q;

	logic signed [15:0] ax_q, ay_q, az_q, gx_q, gy_q, gz_q;
	logic        [15:0] ticks_q;

	logic signed [31:0] roll_store_q, pitch_store_q, yaw_store_q;
	logic signed [31:0] roll_q, pitch_q, yaw_q;
	logic               out_valid_q;

	logic signed [31:0] g_roll, g_pitch, g_yaw, t_roll, t_pitch, b_roll, b_pitch;
	icaf_pkg::lane_stat_t st_gx, st_gy, st_gz, st_tr, st_tp, st_br, st_bp;

	logic lane_start, blend_start, lanes_done, blend_done, out_free, load_out;

	assign in_ready    = (state_q == icaf_pkg::S_IDLE);
	assign lane_start  = (state_q == icaf_pkg::S_START);
	assign lanes_done  = st_gx.done & st_gy.done & st_gz.done & st_tr.done & st_tp.done;
	assign blend_start = (state_q == icaf_pkg::S_LANES) && lanes_done;
	assign blend_done  = st_br.done & st_bp.done;
	assign out_free    = !out_valid_q || out_ready;
	assign load_out    = (state_q == icaf_pkg::S_OUT) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blend_weight_q <= 17'd62915;
			tick_period_q  <= 24'd596571;
			gyro_sens_q    <= 8'd131;
			off_x_q        <= '0;
			off_y_q        <= '0;
			off_z_q        <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				icaf_pkg::CFG_BLEND_WEIGHT: blend_weight_q <= cfg_data[16:0];
				icaf_pkg::CFG_TICK_PERIOD:  tick_period_q  <= cfg_data;
				icaf_pkg::CFG_GYRO_SENS:    gyro_sens_q    <= cfg_data[7:0];
				icaf_pkg::CFG_OFFSET_X:     off_x_q        <= cfg_data[15:0];
				icaf_pkg::CFG_OFFSET_Y:     off_y_q        <= cfg_data[15:0];
				icaf_pkg::CFG_OFFSET_Z:     off_z_q        <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= icaf_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			icaf_pkg::S_IDLE:  if (in_valid) state_d = icaf_pkg::S_START;
			icaf_pkg::S_START: state_d = icaf_pkg::S_LANES;
			icaf_pkg::S_LANES: if (lanes_done) state_d = icaf_pkg::S_BLEND;
			icaf_pkg::S_BLEND: if (blend_done) state_d = icaf_pkg::S_OUT;
			icaf_pkg::S_OUT:   if (out_free) state_d = icaf_pkg::S_IDLE;
			default:           state_d = icaf_pkg::S_IDLE;
		endcase
	end

	// sample word capture and output word load
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			ax_q    <= accel_x;
			ay_q    <= accel_y;
			az_q    <= accel_z;
			gx_q    <= rate_x;
			gy_q    <= rate_y;
			gz_q    <= rate_z;
			ticks_q <= elapsed_ticks;
		end
		if (load_out) begin
			roll_q  <= b_roll;
			pitch_q <= b_pitch;
			yaw_q   <= g_yaw;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			roll_store_q  <= '0;
			pitch_store_q <= '0;
			yaw_store_q   <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (load_out) begin
				roll_store_q  <= b_roll;
				pitch_store_q <= b_pitch;
				yaw_store_q   <= g_yaw;
				out_valid_q   <= 1'b1;
			end else if (out_ready) begin
				out_valid_q   <= 1'b0;
			end
		end
	end

	icaf_gyro_lane u_gyro_x (
		.clk, .arst_n, .start(lane_start), .raw(gx_q), .offset(off_x_q),
		.ticks(ticks_q), .tick_period(tick_period_q), .sens(gyro_sens_q),
		.store(roll_store_q), .angle(g_roll), .stat(st_gx)
	);

	icaf_gyro_lane u_gyro_y (
		.clk, .arst_n, .start(lane_start), .raw(gy_q), .offset(off_y_q),
		.ticks(ticks_q), .tick_period(tick_period_q), .sens(gyro_sens_q),
		.store(pitch_store_q), .angle(g_pitch), .stat(st_gy)
	);

	icaf_gyro_lane u_gyro_z (
		.clk, .arst_n, .start(lane_start), .raw(gz_q), .offset(off_z_q),
		.ticks(ticks_q), .tick_period(tick_period_q), .sens(gyro_sens_q),
		.store(yaw_store_q), .angle(g_yaw), .stat(st_gz)
	);

	icaf_tilt_lane u_tilt_roll (
		.clk, .arst_n, .start(lane_start), .num(ay_q), .den(az_q),
		.angle(t_roll), .stat(st_tr)
	);

	icaf_tilt_lane u_tilt_pitch (
		.clk, .arst_n, .start(lane_start), .num(ax_q), .den(az_q),
		.angle(t_pitch), .stat(st_tp)
	);

	icaf_blend u_blend_roll (
		.clk, .arst_n, .start(blend_start), .weight(blend_weight_q),
		.gyro(g_roll), .tilt(t_roll), .angle(b_roll), .stat(st_br)
	);

	icaf_blend u_blend_pitch (
		.clk, .arst_n, .start(blend_start), .weight(blend_weight_q),
		.gyro(g_pitch), .tilt(t_pitch), .angle(b_pitch), .stat(st_bp)
	);

	assign out_valid   = out_valid_q;
	assign roll_angle  = roll_q;
	assign pitch_angle = pitch_q;
	assign yaw_angle   = yaw_q;

	a_lanes_start: assert property (@(posedge clk) disable iff (!arst_n)
		lane_start |=> (st_gx.busy && st_gy.busy && st_gz.busy))
		else $error("gyro lanes did not start");

	a_blend_after_lanes: assert property (@(posedge clk) disable iff (!arst_n)
		blend_start |-> (st_tr.done && st_tp.done && st_gz.done))
		else $error("blend started before lanes finished");

	a_out_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> (out_valid_q && state_q == icaf_pkg::S_IDLE))
		else $error("result word not presented");

	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == icaf_pkg::S_IDLE) |-> !(st_gx.busy || st_br.busy || st_tr.busy))
		else $error("lane busy while idle");

endmodule
